@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions; they vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: invariant broken");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication broken");

// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication broken");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/sfca_pkg.sv @@
// ----------------------------------------------------------------------------
// sfca_pkg
// Types, constants and the CRC-8 step shared by the frame check and alarm block.
// ----------------------------------------------------------------------------
package sfca_pkg;

	// frame layout: three words of high byte, low byte, check byte
	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] POS_HI_CO2   = 4'd0;
	localparam logic [POS_W-1:0] POS_LO_CO2   = 4'd1;
	localparam logic [POS_W-1:0] POS_CRC_CO2  = 4'd2;
	localparam logic [POS_W-1:0] POS_HI_TEMP  = 4'd3;
	localparam logic [POS_W-1:0] POS_LO_TEMP  = 4'd4;
	localparam logic [POS_W-1:0] POS_CRC_TEMP = 4'd5;
	localparam logic [POS_W-1:0] POS_HI_HUM   = 4'd6;
	localparam logic [POS_W-1:0] POS_LO_HUM   = 4'd7;
	localparam logic [POS_W-1:0] POS_LAST     = 4'd8;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP_OFFSET = 3'd0,
		CFG_HUM_OFFSET  = 3'd1,
		CFG_CO2_OFFSET  = 3'd2,
		CFG_TEMP_HIGH   = 3'd3,
		CFG_TEMP_LOW    = 3'd4,
		CFG_HUM_HIGH    = 3'd5,
		CFG_HUM_LOW     = 3'd6,
		CFG_CO2_HIGH    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [11:0] temp_offset;
		logic signed [11:0] hum_offset;
		logic signed [13:0] co2_offset;
		logic signed [14:0] temp_high;
		logic signed [14:0] temp_low;
		logic signed [14:0] hum_high;
		logic signed [14:0] hum_low;
		logic        [15:0] co2_high;
	} cfg_t;

	localparam logic signed [14:0] RST_TEMP_HIGH = 15'sd3000;
	localparam logic signed [14:0] RST_TEMP_LOW  = 15'sd1000;
	localparam logic signed [14:0] RST_HUM_HIGH  = 15'sd7000;
	localparam logic signed [14:0] RST_HUM_LOW   = 15'sd3000;
	localparam logic        [15:0] RST_CO2_HIGH  = 16'd1500;

	// scaling: value = base + (span * raw + half) / full_scale
	localparam logic [14:0] TEMP_SPAN  = 15'd17500;
	localparam logic [13:0] HUM_SPAN   = 14'd10000;
	localparam logic [30:0] ROUND_HALF = 31'd32767;
	localparam logic [16:0] FULL_SCALE = 17'd65535;
	localparam logic signed [15:0] TEMP_BASE = -16'sd4500;

	localparam logic signed [14:0] TEMP_MIN = -15'sd6500;
	localparam logic signed [14:0] TEMP_MAX = 15'sd15000;
	localparam logic signed [14:0] HUM_MIN  = -15'sd2000;
	localparam logic signed [14:0] HUM_MAX  = 15'sd12000;

	typedef struct packed {
		logic co2_ok;
		logic temp_ok;
		logic hum_ok;
	} crc_flags_t;

	typedef struct packed {
		logic       temp;
		logic       hum;
		logic       co2;
	} alerts_t;

	typedef struct packed {
		logic [15:0] co2_word;
		logic [15:0] temp_word;
		logic [15:0] hum_word;
		crc_flags_t  flags;
	} raw_frame_t;

	typedef struct packed {
		logic [15:0] co2_word;
		logic [14:0] temp_scaled;
		logic [13:0] hum_scaled;
		crc_flags_t  flags;
	} scaled_t;

	// one CRC-8 byte update, MSB first, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

@@ src/sfca_if.sv @@
// ----------------------------------------------------------------------------
// sfca channel interfaces
// Valid/ready channels for frame bytes, results and configuration writes.
// ----------------------------------------------------------------------------
interface sfca_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, data_byte, frame_start, input ready);
	modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface sfca_result_if;
	logic               valid;
	logic               ready;
	logic        [15:0] co2_ppm;
	logic signed [14:0] temperature_centi;
	logic signed [14:0] humidity_centi;
	logic               co2_crc_ok;
	logic               temp_crc_ok;
	logic               hum_crc_ok;
	logic               frame_ok;
	logic               alert_temp;
	logic               alert_hum;
	logic               alert_co2;

	modport source (output valid, co2_ppm, temperature_centi, humidity_centi, co2_crc_ok,
		temp_crc_ok, hum_crc_ok, frame_ok, alert_temp, alert_hum, alert_co2, input ready);
	modport sink   (input valid, co2_ppm, temperature_centi, humidity_centi, co2_crc_ok,
		temp_crc_ok, hum_crc_ok, frame_ok, alert_temp, alert_hum, alert_co2, output ready);
endinterface

interface sfca_cfg_if import sfca_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ src/sensor_frame_check_and_alarm.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_check_and_alarm
// Checks nine-byte measurement frames and raises threshold alerts.
// ----------------------------------------------------------------------------
// Usage:
//   frame  - one byte per beat, high data byte first; frame_start marks byte 0
//            and drops any partial frame. After the ninth byte the next byte
//            opens a new frame on its own.
//   result - one beat per frame, on the ninth byte: held CO2, temperature and
//            humidity, the three CRC-8 flags, frame_ok and the held alerts.
//            A frame with a bad check byte leaves values and alerts unchanged.
//   cfg    - register writes (offsets, thresholds), always ready; write only
//            while no frame result is outstanding.
// Throughput: one byte per cycle while frame ready is high. The edge that takes
// the ninth byte loads the raw register; the multiply, divide, offset/clamp and
// result registers follow in that order.
// A stalled result beat does not stop byte intake: bytes keep flowing until the
// closing byte of a frame finds the raw stage still occupied.
// Reset clears the byte position, CRC, held values and alerts, and loads the
// default thresholds; no result is pending after reset.
// ----------------------------------------------------------------------------
module sensor_frame_check_and_alarm import sfca_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sfca_frame_if.sink    frame,
	sfca_result_if.source result,
	sfca_cfg_if.sink      cfg
);

	cfg_t       regs;
	logic       raw_valid;
	logic       raw_ready;
	raw_frame_t raw;
	logic       scaled_valid;
	logic       scaled_ready;
	scaled_t    scaled;

	sfca_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sfca_frame_rx u_frame_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.raw_valid (raw_valid),
		.raw       (raw),
		.raw_ready (raw_ready)
	);

	sfca_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.raw_valid    (raw_valid),
		.raw          (raw),
		.raw_ready    (raw_ready),
		.scaled_valid (scaled_valid),
		.scaled       (scaled),
		.scaled_ready (scaled_ready)
	);

	sfca_alarm u_alarm (
		.clk          (clk),
		.arst_n       (arst_n),
		.regs         (regs),
		.scaled_valid (scaled_valid),
		.scaled       (scaled),
		.scaled_ready (scaled_ready),
		.result       (result)
	);

endmodule

@@ src/sfca_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sfca_cfg_regs
// Offset and threshold register file behind the configuration write channel.
// ----------------------------------------------------------------------------
module sfca_cfg_regs import sfca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sfca_cfg_if.sink    cfg,
	output cfg_t        regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.temp_offset <= '0;
			regs_q.hum_offset  <= '0;
			regs_q.co2_offset  <= '0;
			regs_q.temp_high   <= RST_TEMP_HIGH;
			regs_q.temp_low    <= RST_TEMP_LOW;
			regs_q.hum_high    <= RST_HUM_HIGH;
			regs_q.hum_low     <= RST_HUM_LOW;
			regs_q.co2_high    <= RST_CO2_HIGH;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_TEMP_OFFSET: regs_q.temp_offset <= cfg.data[11:0];
				CFG_HUM_OFFSET:  regs_q.hum_offset  <= cfg.data[11:0];
				CFG_CO2_OFFSET:  regs_q.co2_offset  <= cfg.data[13:0];
				CFG_TEMP_HIGH:   regs_q.temp_high   <= cfg.data[14:0];
				CFG_TEMP_LOW:    regs_q.temp_low    <= cfg.data[14:0];
				CFG_HUM_HIGH:    regs_q.hum_high    <= cfg.data[14:0];
				CFG_HUM_LOW:     regs_q.hum_low     <= cfg.data[14:0];
				CFG_CO2_HIGH:    regs_q.co2_high    <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

endmodule

@@ src/sfca_frame_rx.sv @@
// ----------------------------------------------------------------------------
// sfca_frame_rx
// Tracks the byte position, runs the CRC-8 and assembles the three raw words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfca_frame_rx import sfca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sfca_frame_if.sink  frame,
	output logic        raw_valid,
	output raw_frame_t  raw,
	input  logic        raw_ready
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       crc_q;
	logic [7:0]       high_q;
	logic [7:0]       low_q;
	logic [15:0]      co2_word_q;
	logic [15:0]      temp_word_q;
	logic             co2_ok_q;
	logic             temp_ok_q;
	logic             raw_valid_s1;
	raw_frame_t       raw_s1;

	logic [POS_W-1:0] pos_eff;
	logic [7:0]       crc_cur;
	logic             is_check;
	logic             check_ok;
	logic             accept;
	logic             s1_free;

	always_comb begin
		// a start flag or a stray position restarts the frame
		pos_eff  = (frame.frame_start || (pos_q > POS_LAST)) ? '0 : pos_q;
		crc_cur  = frame.frame_start ? CRC_INIT : crc_q;
		is_check = (pos_eff == POS_CRC_CO2) || (pos_eff == POS_CRC_TEMP) ||
			(pos_eff == POS_LAST);
		check_ok = (frame.data_byte == crc_cur);
	end

	assign s1_free     = !raw_valid_s1 || raw_ready;
	// only the closing byte needs room downstream
	assign frame.ready = (pos_q != POS_LAST) || s1_free;
	assign accept      = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			crc_q       <= CRC_INIT;
			high_q      <= '0;
			low_q       <= '0;
			co2_word_q  <= '0;
			temp_word_q <= '0;
			co2_ok_q    <= 1'b0;
			temp_ok_q   <= 1'b0;
		end else if (accept) begin
			crc_q <= is_check ? CRC_INIT : crc8_byte(crc_cur, frame.data_byte);
			pos_q <= (pos_eff == POS_LAST) ? '0 : pos_eff + 1'b1;
			case (pos_eff)
				POS_HI_CO2, POS_HI_TEMP, POS_HI_HUM: high_q <= frame.data_byte;
				POS_LO_CO2:   co2_word_q  <= {high_q, frame.data_byte};
				POS_LO_TEMP:  temp_word_q <= {high_q, frame.data_byte};
				POS_LO_HUM:   low_q       <= frame.data_byte;
				POS_CRC_CO2:  co2_ok_q    <= check_ok;
				POS_CRC_TEMP: temp_ok_q   <= check_ok;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_valid_s1 <= 1'b0;
		end else if (accept && (pos_eff == POS_LAST)) begin
			raw_valid_s1 <= 1'b1;
		end else if (raw_ready) begin
			raw_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (pos_eff == POS_LAST)) begin
			raw_s1.co2_word      <= co2_word_q;
			raw_s1.temp_word     <= temp_word_q;
			raw_s1.hum_word      <= {high_q, low_q};
			raw_s1.flags.co2_ok  <= co2_ok_q;
			raw_s1.flags.temp_ok <= temp_ok_q;
			raw_s1.flags.hum_ok  <= check_ok;
		end
	end

	assign raw_valid = raw_valid_s1;
	assign raw       = raw_s1;

	`ASSERT_HOLDS(a_pos_range, clk, arst_n, pos_q <= POS_LAST)
	`ASSERT_NEXT(a_crc_reinit, clk, arst_n, accept && is_check, crc_q == CRC_INIT)
	`ASSERT_IMPLIES(a_no_overrun, clk, arst_n, accept && (pos_eff == POS_LAST), s1_free)

endmodule

@@ src/sfca_scale.sv @@
// ----------------------------------------------------------------------------
// sfca_scale
// Multiplies the raw words by their span, then divides by full scale with rounding.
// ----------------------------------------------------------------------------
module sfca_scale import sfca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        raw_valid,
	input  raw_frame_t  raw,
	output logic        raw_ready,
	output logic        scaled_valid,
	output scaled_t     scaled,
	input  logic        scaled_ready
);

	logic        valid_s2;
	logic [30:0] temp_prod_s2;
	logic [30:0] hum_prod_s2;
	logic [15:0] co2_word_s2;
	crc_flags_t  flags_s2;

	logic        valid_s3;
	scaled_t     scaled_s3;

	logic        s2_free;
	logic        s3_free;

	// (p + half) / 65535: take x >> 16, then one correction step
	function automatic logic [14:0] div_full_scale(input logic [30:0] prod);
		logic [30:0] x;
		logic [14:0] q0;
		logic [16:0] r;
		x  = prod + ROUND_HALF;
		q0 = x[30:16];
		r  = {1'b0, x[15:0]} + {2'b0, q0};
		return (r >= FULL_SCALE) ? q0 + 1'b1 : q0;
	endfunction

	assign s3_free   = !valid_s3 || scaled_ready;
	assign s2_free   = !valid_s2 || s3_free;
	assign raw_ready = s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= raw_valid;
			end
			if (s3_free) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && raw_valid) begin
			temp_prod_s2 <= {16'b0, TEMP_SPAN} * {15'b0, raw.temp_word};
			hum_prod_s2  <= {17'b0, HUM_SPAN} * {15'b0, raw.hum_word};
			co2_word_s2  <= raw.co2_word;
			flags_s2     <= raw.flags;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && valid_s2) begin
			scaled_s3.co2_word    <= co2_word_s2;
			scaled_s3.temp_scaled <= div_full_scale(temp_prod_s2);
			scaled_s3.hum_scaled  <= 14'(div_full_scale(hum_prod_s2));
			scaled_s3.flags       <= flags_s2;
		end
	end

	assign scaled_valid = valid_s3;
	assign scaled       = scaled_s3;

endmodule

@@ src/sfca_alarm.sv @@
// ----------------------------------------------------------------------------
// sfca_alarm
// Applies offsets and limits, compares thresholds and holds the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfca_alarm import sfca_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         regs,
	input  logic         scaled_valid,
	input  scaled_t      scaled,
	output logic         scaled_ready,
	sfca_result_if.source result
);

	logic               valid_s4;
	logic        [15:0] co2_s4;
	logic signed [14:0] temp_s4;
	logic signed [14:0] hum_s4;
	crc_flags_t         flags_s4;

	logic               res_valid_q;
	logic        [15:0] co2_q;
	logic signed [14:0] temp_q;
	logic signed [14:0] hum_q;
	alerts_t            alerts_q;
	crc_flags_t         flags_q;
	logic               frame_ok_q;

	logic               s4_free;
	logic               load;
	logic               all_ok;
	logic signed [15:0] temp_sum;
	logic signed [15:0] hum_sum;
	logic signed [17:0] co2_sum;
	logic signed [14:0] temp_lim;
	logic signed [14:0] hum_lim;
	logic        [15:0] co2_lim;
	alerts_t            alerts_new;
	logic               keep_held;
	logic               held_in_range;

	assign load         = valid_s4 && (!res_valid_q || result.ready);
	assign s4_free      = !valid_s4 || load;
	assign scaled_ready = s4_free;
	assign all_ok       = flags_s4.co2_ok && flags_s4.temp_ok && flags_s4.hum_ok;

	always_comb begin
		temp_sum = $signed({1'b0, scaled.temp_scaled}) + TEMP_BASE +
			$signed({{4{regs.temp_offset[11]}}, regs.temp_offset});
		hum_sum  = $signed({2'b0, scaled.hum_scaled}) +
			$signed({{4{regs.hum_offset[11]}}, regs.hum_offset});
		co2_sum  = $signed({2'b0, scaled.co2_word}) +
			$signed({{4{regs.co2_offset[13]}}, regs.co2_offset});

		if (temp_sum < 16'(TEMP_MIN)) begin
			temp_lim = TEMP_MIN;
		end else if (temp_sum > 16'(TEMP_MAX)) begin
			temp_lim = TEMP_MAX;
		end else begin
			temp_lim = temp_sum[14:0];
		end

		if (hum_sum < 16'(HUM_MIN)) begin
			hum_lim = HUM_MIN;
		end else if (hum_sum > 16'(HUM_MAX)) begin
			hum_lim = HUM_MAX;
		end else begin
			hum_lim = hum_sum[14:0];
		end

		// negative sum floors at zero, anything past 16 bits saturates
		if (co2_sum[17]) begin
			co2_lim = '0;
		end else if (co2_sum[16]) begin
			co2_lim = '1;
		end else begin
			co2_lim = co2_sum[15:0];
		end
	end

	always_comb begin
		alerts_new.temp = (temp_s4 > regs.temp_high) || (temp_s4 < regs.temp_low);
		alerts_new.hum  = (hum_s4 > regs.hum_high) || (hum_s4 < regs.hum_low);
		alerts_new.co2  = (co2_s4 > regs.co2_high);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (s4_free) begin
			valid_s4 <= scaled_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_free && scaled_valid) begin
			co2_s4   <= co2_lim;
			temp_s4  <= temp_lim;
			hum_s4   <= hum_lim;
			flags_s4 <= scaled.flags;
		end
	end

	// held values double as the result register; a failed frame keeps them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			co2_q       <= '0;
			temp_q      <= '0;
			hum_q       <= '0;
			alerts_q    <= '0;
			flags_q     <= '0;
			frame_ok_q  <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				flags_q     <= flags_s4;
				frame_ok_q  <= all_ok;
				if (all_ok) begin
					co2_q    <= co2_s4;
					temp_q   <= temp_s4;
					hum_q    <= hum_s4;
					alerts_q <= alerts_new;
				end
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid             = res_valid_q;
	assign result.co2_ppm           = co2_q;
	assign result.temperature_centi = temp_q;
	assign result.humidity_centi    = hum_q;
	assign result.co2_crc_ok        = flags_q.co2_ok;
	assign result.temp_crc_ok       = flags_q.temp_ok;
	assign result.hum_crc_ok        = flags_q.hum_ok;
	assign result.frame_ok          = frame_ok_q;
	assign result.alert_temp        = alerts_q.temp;
	assign result.alert_hum         = alerts_q.hum;
	assign result.alert_co2         = alerts_q.co2;

	assign keep_held     = !(load && all_ok);
	assign held_in_range = (temp_q >= TEMP_MIN) && (temp_q <= TEMP_MAX) &&
		(hum_q >= HUM_MIN) && (hum_q <= HUM_MAX);

	`ASSERT_IMPLIES(a_ok_means_all, clk, arst_n, res_valid_q, frame_ok_q == (&flags_q))
	`ASSERT_NEXT(a_hold_on_fail, clk, arst_n, keep_held, $stable({co2_q, temp_q, hum_q, alerts_q}))
	`ASSERT_HOLDS(a_held_in_range, clk, arst_n, held_in_range)

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams nine-byte measurement frames (good, corrupted, cut short and plain
// noise) into the frame checker under random idling on both sides, decodes
// every accepted byte in a local frame decoder and compares each reading
// beat, field by field, with the oldest reading that the decoder predicts.
// ----------------------------------------------------------------------------
module testbench;
	import sfca_pkg::*;

	localparam int FRAME_BYTES = 9;
	localparam int ITEM_TARGET = 1950;
	localparam int STEADY_FRAMES = 20;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [15:0] co2;
		logic [14:0] temp;
		logic [14:0] hum;
		logic        co2_ok;
		logic        temp_ok;
		logic        hum_ok;
		logic        frame_ok;
		logic        al_temp;
		logic        al_hum;
		logic        al_co2;
	} reading_t;

	logic clk;
	logic arst_n;

	sfca_frame_if  frame_ch ();
	sfca_result_if res_ch ();
	sfca_cfg_if    cfg_ch ();

	sensor_frame_check_and_alarm u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// register copies
	logic signed [11:0] temp_ofs;
	logic signed [11:0] hum_ofs;
	logic signed [13:0] co2_ofs;
	logic signed [14:0] temp_hi;
	logic signed [14:0] temp_lo;
	logic signed [14:0] hum_hi;
	logic signed [14:0] hum_lo;
	logic        [15:0] co2_hi;

	// frame decoder state
	logic [POS_W-1:0]   frame_pos;
	logic [7:0]         frame_crc;
	logic [7:0]         hi_byte;
	logic [7:0]         lo_byte;
	logic [15:0]        co2_word;
	logic [15:0]        temp_word;
	logic               co2_pass;
	logic               temp_pass;
	logic [15:0]        held_co2;
	logic signed [14:0] held_temp;
	logic signed [14:0] held_hum;
	logic               held_al_temp;
	logic               held_al_hum;
	logic               held_al_co2;

	reading_t pending_readings [$];

	int bytes_sent = 0;
	int errors = 0;
	int reported = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_req = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] word_check(logic [15:0] w);
		return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
	endfunction

	function automatic void reset_decoder();
		temp_ofs = '0;
		hum_ofs = '0;
		co2_ofs = '0;
		temp_hi = RST_TEMP_HIGH;
		temp_lo = RST_TEMP_LOW;
		hum_hi = RST_HUM_HIGH;
		hum_lo = RST_HUM_LOW;
		co2_hi = RST_CO2_HIGH;
		frame_pos = POS_HI_CO2;
		frame_crc = CRC_INIT;
		hi_byte = '0;
		lo_byte = '0;
		co2_word = '0;
		temp_word = '0;
		co2_pass = 1'b0;
		temp_pass = 1'b0;
		held_co2 = '0;
		held_temp = '0;
		held_hum = '0;
		held_al_temp = 1'b0;
		held_al_hum = 1'b0;
		held_al_co2 = 1'b0;
	endfunction

	// advance the decoder by one accepted byte; queue a reading on the closing byte
	function automatic void decode_frame_byte(logic [7:0] b, logic fs);
		int t;
		int h;
		int c;
		logic ok;
		logic all_ok;
		reading_t r;
		if (fs) begin
			frame_pos = POS_HI_CO2;
			frame_crc = CRC_INIT;
		end
		if (frame_pos > POS_LAST)
			frame_pos = POS_HI_CO2;
		case (frame_pos)
			POS_CRC_CO2, POS_CRC_TEMP, POS_LAST: begin
				ok = (b == frame_crc);
				frame_crc = CRC_INIT;
				if (frame_pos == POS_CRC_CO2)
					co2_pass = ok;
				else if (frame_pos == POS_CRC_TEMP)
					temp_pass = ok;
				if (frame_pos != POS_LAST) begin
					frame_pos = frame_pos + 1'b1;
					return;
				end
				frame_pos = POS_HI_CO2;
				all_ok = co2_pass && temp_pass && ok;
				if (all_ok) begin
					t = -4500 + int'((64'd17500 * temp_word + 64'd32767) / 64'd65535);
					h = int'((64'd10000 * {hi_byte, lo_byte} + 64'd32767) / 64'd65535);
					c = int'(co2_word) + int'(co2_ofs);
					t = t + int'(temp_ofs);
					h = h + int'(hum_ofs);
					if (t < int'(TEMP_MIN)) t = int'(TEMP_MIN);
					if (t > int'(TEMP_MAX)) t = int'(TEMP_MAX);
					if (h < int'(HUM_MIN)) h = int'(HUM_MIN);
					if (h > int'(HUM_MAX)) h = int'(HUM_MAX);
					if (c < 0) c = 0;
					if (c > 65535) c = 65535;
					held_temp = t[14:0];
					held_hum = h[14:0];
					held_co2 = c[15:0];
					held_al_temp = (t > int'(temp_hi)) || (t < int'(temp_lo));
					held_al_hum = (h > int'(hum_hi)) || (h < int'(hum_lo));
					held_al_co2 = c > int'(co2_hi);
				end
				r.co2 = held_co2;
				r.temp = held_temp;
				r.hum = held_hum;
				r.co2_ok = co2_pass;
				r.temp_ok = temp_pass;
				r.hum_ok = ok;
				r.frame_ok = all_ok;
				r.al_temp = held_al_temp;
				r.al_hum = held_al_hum;
				r.al_co2 = held_al_co2;
				pending_readings.push_back(r);
			end
			default: begin
				frame_crc = crc8_step(frame_crc, b);
				case (frame_pos)
					POS_HI_CO2, POS_HI_TEMP, POS_HI_HUM: hi_byte = b;
					POS_LO_CO2: co2_word = {hi_byte, b};
					POS_LO_TEMP: temp_word = {hi_byte, b};
					default: lo_byte = b;
				endcase
				frame_pos = frame_pos + 1'b1;
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			if (reported < 10) begin
				reported++;
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			end
		end
	endfunction

	always @(posedge clk) begin : reading_check
		reading_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_readings.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("%0t: reading beat with nothing pending", $time);
				end
			end else begin
				want = pending_readings.pop_front();
				check_field("co2_ppm", want.co2, res_ch.co2_ppm);
				check_field("temperature_centi", {1'b0, want.temp},
					{1'b0, res_ch.temperature_centi});
				check_field("humidity_centi", {1'b0, want.hum}, {1'b0, res_ch.humidity_centi});
				check_field("co2_crc_ok", 16'(want.co2_ok), 16'(res_ch.co2_crc_ok));
				check_field("temp_crc_ok", 16'(want.temp_ok), 16'(res_ch.temp_crc_ok));
				check_field("hum_crc_ok", 16'(want.hum_ok), 16'(res_ch.hum_crc_ok));
				check_field("frame_ok", 16'(want.frame_ok), 16'(res_ch.frame_ok));
				check_field("alert_temp", 16'(want.al_temp), 16'(res_ch.alert_temp));
				check_field("alert_hum", 16'(want.al_hum), 16'(res_ch.alert_hum));
				check_field("alert_co2", 16'(want.al_co2), 16'(res_ch.alert_co2));
			end
		end
	end

	// reading sink: random stalls, plus one long hold-off on request
	initial begin : reading_sink
		int n;
		res_ch.ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (stall_req != 0) begin
				n = stall_req;
				stall_req = 0;
				res_ch.ready <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				n = $urandom_range(1, 7);
				res_ch.ready <= 1'b0;
			end else begin
				n = $urandom_range(1, 8);
				res_ch.ready <= 1'b1;
			end
			repeat (n) @(posedge clk);
		end
	end

	task automatic send_byte(logic [7:0] b, logic fs);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			frame_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.data_byte <= b;
		frame_ch.frame_start <= fs;
		do @(posedge clk); while (!frame_ch.ready);
		decode_frame_byte(b, fs);
		bytes_sent++;
	endtask

	// bad_checks bit 0 spoils the CO2 check byte, bit 1 temperature, bit 2 humidity
	task automatic send_frame(logic [15:0] co2_raw, logic [15:0] temp_raw,
		logic [15:0] hum_raw, logic [2:0] bad_checks, bit mark_start, int length);
		logic [7:0] fb [FRAME_BYTES];
		logic [15:0] words [3];
		words[0] = co2_raw;
		words[1] = temp_raw;
		words[2] = hum_raw;
		for (int w = 0; w < 3; w++) begin
			fb[3*w] = words[w][15:8];
			fb[3*w+1] = words[w][7:0];
			fb[3*w+2] = word_check(words[w]);
			if (bad_checks[w])
				fb[3*w+2] = fb[3*w+2] ^ 8'($urandom_range(1, 255));
		end
		for (int i = 0; i < length; i++)
			send_byte(fb[i], mark_start && i == 0);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// wait for every reading, then let the pipeline run dry before a write
	task automatic write_reg(cfg_idx_t idx, logic [15:0] d);
		frame_ch.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_TEMP_OFFSET: temp_ofs = d[11:0];
			CFG_HUM_OFFSET:  hum_ofs = d[11:0];
			CFG_CO2_OFFSET:  co2_ofs = d[13:0];
			CFG_TEMP_HIGH:   temp_hi = d[14:0];
			CFG_TEMP_LOW:    temp_lo = d[14:0];
			CFG_HUM_HIGH:    hum_hi = d[14:0];
			CFG_HUM_LOW:     hum_lo = d[14:0];
			default:         co2_hi = d;
		endcase
	endtask

	task automatic load_settings(int t_ofs, int h_ofs, int c_ofs, int t_hi, int t_lo,
		int h_hi, int h_lo, int c_hi);
		write_reg(CFG_TEMP_OFFSET, 16'(t_ofs));
		write_reg(CFG_HUM_OFFSET, 16'(h_ofs));
		write_reg(CFG_CO2_OFFSET, 16'(c_ofs));
		write_reg(CFG_TEMP_HIGH, 16'(t_hi));
		write_reg(CFG_TEMP_LOW, 16'(t_lo));
		write_reg(CFG_HUM_HIGH, 16'(h_hi));
		write_reg(CFG_HUM_LOW, 16'(h_lo));
		write_reg(CFG_CO2_HIGH, 16'(c_hi));
	endtask

	// value within the register's usual range or at a field extreme; unused bits random
	function automatic logic [15:0] pick_reg_value(cfg_idx_t idx);
		int lo;
		int hi;
		int w;
		int fmin;
		int fmax;
		int v;
		logic [15:0] d;
		logic [15:0] mask;
		case (idx)
			CFG_TEMP_OFFSET, CFG_HUM_OFFSET: begin
				lo = -2000; hi = 2000; w = 12;
			end
			CFG_CO2_OFFSET: begin
				lo = -5000; hi = 5000; w = 14;
			end
			CFG_TEMP_HIGH, CFG_TEMP_LOW: begin
				lo = -6500; hi = 15000; w = 15;
			end
			CFG_HUM_HIGH, CFG_HUM_LOW: begin
				lo = -2000; hi = 12000; w = 15;
			end
			default: begin
				lo = 0; hi = 65535; w = 16;
			end
		endcase
		if (idx == CFG_CO2_HIGH) begin
			fmin = 0;
			fmax = 65535;
		end else begin
			fmin = -(1 << (w - 1));
			fmax = (1 << (w - 1)) - 1;
		end
		case ($urandom_range(0, 7))
			0: v = fmin;
			1: v = fmax;
			default: v = lo + int'($urandom_range(0, hi - lo));
		endcase
		d = 16'(v);
		mask = 16'((32'h1 << w) - 1);
		return (d & mask) | (16'($urandom) & ~mask);
	endfunction

	task automatic write_random_settings();
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 1) == 1)
				write_reg(cfg_idx_t'(i), pick_reg_value(cfg_idx_t'(i)));
		end
	endtask

	task automatic check_directed_frames();
		gap_pct = 20;
		stall_pct = 20;
		// partial frame, dropped by the next frame_start
		send_frame(16'h1234, 16'h5678, 16'h9ABC, 3'b000, 1, 4);
		send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, 1, FRAME_BYTES);
		// frame opens on its own after a closing byte
		send_frame(16'h0000, 16'h0000, 16'h0000, 3'b000, 0, FRAME_BYTES);
		// bad temperature check: held values stay
		send_frame(16'h0400, 16'h6666, 16'h8000, 3'b010, 0, FRAME_BYTES);
	endtask

	task automatic send_probe_frames();
		send_frame(16'h0000, 16'h0000, 16'h0000, 3'b000, 1, FRAME_BYTES);
		send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, 1, FRAME_BYTES);
		send_frame(pick_word(), pick_word(), pick_word(), 3'b000, 1, FRAME_BYTES);
		send_frame(pick_word(), pick_word(), pick_word(), 3'b000, 0, FRAME_BYTES);
	endtask

	task automatic check_register_extremes();
		load_settings(-2048, -2048, -8192, -16384, -16384, -16384, -16384, 0);
		send_probe_frames();
		load_settings(2047, 2047, 8191, 16383, 16383, 16383, 16383, 65535);
		send_probe_frames();
		// low above high widens the alert window
		load_settings(0, 0, 0, -6500, 15000, -2000, 12000, 1500);
		send_probe_frames();
		// thresholds equal to the zero-input values: strict compares stay quiet
		load_settings(0, 0, 0, -4500, -4500, 0, 0, 0);
		send_probe_frames();
		load_settings(-2000, 2000, -5000, 15000, -6500, 12000, -2000, 65535);
		send_probe_frames();
		load_settings(0, 0, 0, 3000, 1000, 7000, 3000, 1500);
	endtask

	task automatic check_output_stall();
		gap_pct = 0;
		stall_req = 250;
		for (int i = 0; i < 14; i++)
			send_frame(pick_word(), pick_word(), pick_word(), 3'b000, i == 0, FRAME_BYTES);
		gap_pct = 20;
	endtask

	task automatic check_random_traffic();
		int kind;
		int n;
		bit need_start;
		need_start = 1;
		while (bytes_sent < ITEM_TARGET - STEADY_FRAMES * FRAME_BYTES) begin
			if ($urandom_range(0, 39) == 0)
				write_random_settings();
			if ($urandom_range(0, 15) == 0) begin
				gap_pct = $urandom_range(0, 3) * 20;
				stall_pct = $urandom_range(0, 3) * 20;
			end
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				send_frame(pick_word(), pick_word(), pick_word(), 3'b000,
					need_start || $urandom_range(0, 1) == 1, FRAME_BYTES);
				need_start = 0;
			end else if (kind < 85) begin
				send_frame(pick_word(), pick_word(), pick_word(), 3'($urandom_range(1, 7)),
					need_start || $urandom_range(0, 1) == 1, FRAME_BYTES);
				need_start = 0;
			end else if (kind < 93) begin
				send_frame(pick_word(), pick_word(), pick_word(), 3'b000, 1,
					$urandom_range(1, FRAME_BYTES - 1));
				need_start = 1;
			end else begin
				n = $urandom_range(1, 12);
				repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				need_start = 1;
			end
		end
	endtask

	task automatic check_steady_stream();
		gap_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < STEADY_FRAMES; i++)
			send_frame(pick_word(), pick_word(), pick_word(), 3'b000, i == 0, FRAME_BYTES);
	endtask

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin : main_sequence
		int waited;
		arst_n = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.data_byte = '0;
		frame_ch.frame_start = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		reset_decoder();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_directed_frames();
		check_register_extremes();
		check_output_stall();
		check_random_traffic();
		check_steady_stream();

		frame_ch.valid <= 1'b0;
		waited = 0;
		while (pending_readings.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_readings.size() != 0) begin
			errors += pending_readings.size();
			if (reported < 10) begin
				reported++;
				$display("%0d expected readings never arrived", pending_readings.size());
			end
		end
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
